// File: rtl/core/lea_pkg.sv
// ----------------------------------------------------------------------------
// LEA package
// Shared types, constants and helper functions for the LEA cipher core.
// ----------------------------------------------------------------------------
package lea_pkg;

  localparam int unsigned MaxRounds  = 32;
  localparam int unsigned RkPerRound = 6;

  typedef enum logic [1:0] {
    KLEN_128 = 2'd0,
    KLEN_192 = 2'd1,
    KLEN_256 = 2'd2,
    KLEN_RSV = 2'd3
  } klen_e;

  typedef enum logic [2:0] {
    CFG_KEY_LENGTH = 3'd0,
    CFG_KEY_WORD0  = 3'd1,
    CFG_KEY_WORD1  = 3'd2,
    CFG_KEY_WORD2  = 3'd3,
    CFG_KEY_WORD3  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYGEN,
    ST_LOAD,
    ST_ROUND,
    ST_OUT
  } state_e;

  function automatic logic [31:0] delta(input logic [2:0] idx);
    case (idx)
      3'd0:    delta = 32'hc3efe9db;
      3'd1:    delta = 32'h44626b02;
      3'd2:    delta = 32'h79e27c8a;
      3'd3:    delta = 32'h78df30ec;
      3'd4:    delta = 32'h715ea49e;
      3'd5:    delta = 32'hc785da0a;
      3'd6:    delta = 32'he04ef22a;
      default: delta = 32'he5c40957;
    endcase
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
    logic [63:0] w;
    w = {v, v} << r;
    rotl32 = w[63:32];
  endfunction

endpackage

// File: rtl/core/lea_ram.sv
// ----------------------------------------------------------------------------
// LEA generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module lea_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 192,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/core/lea_block_cipher_top.sv
// ----------------------------------------------------------------------------
// LEA block cipher top
// 128-bit LEA encrypt/decrypt core with 128/192/256-bit key schedule.
// ----------------------------------------------------------------------------
// One 128-bit block per transaction in, one out; s_axis_tuser selects encrypt
// (0) or decrypt (1). A block is accepted only while the core is idle. After
// any configuration write, the first block triggers a key schedule pass. That
// pass writes six round key words per round into a key RAM, one word per
// cycle, over 24/28/32 rounds. The round function reads its six key words one
// at a time, because the key RAM has one read port and gives one key word per
// cycle. A load state comes before the rounds. So m_axis_tvalid rises after
// the load state and the rounds, plus the key schedule when it runs. A new
// block is taken only once the last one has left the output state and the
// core is idle again. Key length code 3 acts as 256-bit. Write configuration
// only while no block is in flight. Writes to unused register indexes are
// ignored.
module lea_block_cipher_top
  import lea_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = MaxRounds
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // block_low[63:0], block_high[127:64]
  input  logic         s_axis_tuser,   // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // result_low[63:0], result_high[127:64]
);
  localparam int unsigned Depth = MAX_ROUNDS * RkPerRound;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned RW    = $clog2(MAX_ROUNDS + 1);

  state_e state_q, state_d;

  logic [1:0]    klen_q;
  logic [63:0]   key_q [4];
  logic          ready_q;
  logic          op_q;
  logic [31:0]   x_q [4];
  logic [31:0]   t_q [8];
  logic [RW-1:0] rnd_q;     // round counter
  logic [2:0]    j_q;       // word in round
  logic [2:0]    dcnt_q;    // delta index: round number mod 4/6/8
  logic [31:0]   kw_q [5];  // round key words gathered so far
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          last_j, last_r;
  logic          cfg_hit;
  logic          kg_done;

  logic [1:0] code;
  logic [RW-1:0] nrounds;
  assign code    = (klen_q == KLEN_RSV) ? KLEN_256 : klen_q;
  assign nrounds = RW'(24 + 4 * int'(code));

  assign last_j = (j_q == 3'd5);
  assign last_r = (rnd_q == nrounds - RW'(1));

  // ---- key schedule step (one stored word per cycle, six per round) ----
  // 128-bit key: stored words are t0 t1 t2 t1 t3 t1; slots 3 and 5 repeat t1.
  logic [2:0]    tk;
  logic [2:0]    rj;
  logic          upd;
  logic [2:0]    didx;
  logic [4:0]    rot;
  logic [31:0]   tnew;
  logic [RW+2:0] six_i;
  always_comb begin
    six_i = (RW+3)'(rnd_q) * (RW+3)'(6) + (RW+3)'(j_q);
    upd   = 1'b1;
    case (code)
      KLEN_128: begin
        case (j_q)
          3'd0:    tk = 3'd0;
          3'd1:    tk = 3'd1;
          3'd2:    tk = 3'd2;
          3'd4:    tk = 3'd3;
          default: tk = 3'd1;
        endcase
        upd  = (j_q != 3'd3) && (j_q != 3'd5);
        rj   = tk;
        didx = {1'b0, dcnt_q[1:0]};
      end
      KLEN_192: begin
        tk = j_q; rj = j_q; didx = dcnt_q;
      end
      default: begin
        tk = six_i[2:0]; rj = j_q; didx = dcnt_q;
      end
    endcase
    case (rj)
      3'd0: rot = 5'd1;
      3'd1: rot = 5'd3;
      3'd2: rot = 5'd6;
      3'd3: rot = 5'd11;
      3'd4: rot = 5'd13;
      default: rot = 5'd17;
    endcase
    tnew = rotl32(t_q[tk] + rotl32(delta(didx), 5'(rnd_q) + 5'(rj)), rot);
  end

  always_comb begin
    we    = (state_q == ST_KEYGEN);
    waddr = AW'(six_i);
    wdata = upd ? tnew : t_q[tk];
  end

  // ---- round computation ----
  // Address for the word after the current one; the registered RAM read returns it in the next cycle.
  logic [RW-1:0] nr;
  logic [2:0]    nj;
  logic [RW-1:0] ridx;
  always_comb begin
    nr = '0;
    nj = '0;
    if (state_q == ST_ROUND) begin
      if (last_j) begin
        nr = last_r ? rnd_q : rnd_q + RW'(1);
      end else begin
        nr = rnd_q;
        nj = j_q + 3'd1;
      end
    end
    ridx  = op_q ? (nrounds - nr - RW'(1)) : nr;
    raddr = AW'((AW+3)'(ridx) * (AW+3)'(6) + (AW+3)'(nj));
  end

  logic [31:0] k [6];
  logic [31:0] e0, e1, e2, n1, n2, n3;
  always_comb begin
    for (int i = 0; i < 5; i++) k[i] = kw_q[i];
    k[5] = rdata;
    e0 = rotl32((x_q[0] ^ k[0]) + (x_q[1] ^ k[1]), 5'd9);
    e1 = rotl32((x_q[1] ^ k[2]) + (x_q[2] ^ k[3]), 5'd27);
    e2 = rotl32((x_q[2] ^ k[4]) + (x_q[3] ^ k[5]), 5'd29);
    n1 = (rotl32(x_q[0], 5'd23) - (x_q[3] ^ k[0])) ^ k[1];
    n2 = (rotl32(x_q[1], 5'd5) - (n1 ^ k[2])) ^ k[3];
    n3 = (rotl32(x_q[2], 5'd3) - (n2 ^ k[4])) ^ k[5];
  end

  // key RAM: round keys written in schedule, read one word per cycle
  lea_ram #(.Width(32), .Depth(Depth)) u_rk (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = ready_q ? ST_LOAD : ST_KEYGEN;
      ST_KEYGEN: if (last_j && last_r) state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_ROUND;
      ST_ROUND:  if (last_j && last_r) state_d = ST_OUT;
      ST_OUT:    if (m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_OUT);
    m_axis_tdata  = {x_q[3], x_q[2], x_q[1], x_q[0]};
  end

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= CFG_KEY_WORD3);
  assign kg_done = (state_q == ST_KEYGEN) && last_j && last_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      klen_q  <= KLEN_128;
      ready_q <= 1'b0;
      rnd_q   <= '0;
      j_q     <= '0;
      dcnt_q  <= '0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_hit) ready_q <= 1'b0;
      else if (kg_done) ready_q <= 1'b1;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_LENGTH: klen_q   <= cfg_data_i[1:0];
          CFG_KEY_WORD0:  key_q[0] <= cfg_data_i;
          CFG_KEY_WORD1:  key_q[1] <= cfg_data_i;
          CFG_KEY_WORD2:  key_q[2] <= cfg_data_i;
          CFG_KEY_WORD3:  key_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_KEYGEN: begin
          if (last_j) begin
            j_q    <= '0;
            rnd_q  <= last_r ? '0 : rnd_q + RW'(1);
            dcnt_q <= (code == KLEN_192 && dcnt_q == 3'd5) ? '0 : dcnt_q + 3'd1;
          end else j_q <= j_q + 3'd1;
        end
        ST_ROUND: begin
          if (last_j) begin
            j_q   <= '0;
            rnd_q <= last_r ? '0 : rnd_q + RW'(1);
          end else j_q <= j_q + 3'd1;
        end
        default: begin
          rnd_q  <= '0;
          j_q    <= '0;
          dcnt_q <= '0;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      for (int i = 0; i < 4; i++) begin
        t_q[2*i]   <= key_q[i][31:0];
        t_q[2*i+1] <= key_q[i][63:32];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op_q   <= s_axis_tuser;
        x_q[0] <= s_axis_tdata[31:0];
        x_q[1] <= s_axis_tdata[63:32];
        x_q[2] <= s_axis_tdata[95:64];
        x_q[3] <= s_axis_tdata[127:96];
      end
    end
    if (state_q == ST_KEYGEN && upd) t_q[tk] <= tnew;
    if (state_q == ST_ROUND) begin
      if (!last_j) begin
        kw_q[j_q] <= rdata;
      end else if (op_q) begin
        // word 5 arrives now; finish one decrypt round
        x_q[0] <= x_q[3];
        x_q[1] <= n1;
        x_q[2] <= n2;
        x_q[3] <= n3;
      end else begin
        x_q[0] <= e0;
        x_q[1] <= e1;
        x_q[2] <= e2;
        x_q[3] <= x_q[0];
      end
    end
  end

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid));
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready);
  a_word_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_q <= 3'd5);
`endif
endmodule

// File: test/lea_block_cipher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LEA block cipher checker
// Watches the config port and both streams, predicts each result block from
// its own LEA key schedule and round functions, and counts mismatches.
// ----------------------------------------------------------------------------
module lea_block_cipher_checker
  import lea_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);

  localparam logic [31:0] Delta [8] = '{32'hc3efe9db, 32'h44626b02, 32'h79e27c8a,
    32'h78df30ec, 32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957};
  localparam int KeyRot [6] = '{1, 3, 6, 11, 13, 17};

  klen_e       klen_q;
  logic [63:0] key_q [4];
  logic [31:0] rk_q [MaxRounds * RkPerRound];
  bit          keys_valid;
  logic [127:0] expected_blocks [$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_blocks.size();

  function automatic logic [31:0] rol(logic [31:0] v, int r);
    r = r % 32;
    return r == 0 ? v : (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] ror(logic [31:0] v, int r);
    return rol(v, 32 - r);
  endfunction

  function automatic int rounds_of(klen_e k);
    case (k)
      KLEN_128: return 24;
      KLEN_192: return 28;
      default:  return 32;
    endcase
  endfunction

  task automatic build_schedule();
    logic [31:0] t [8];
    logic [31:0] d;
    int kk;
    for (int j = 0; j < 4; j++) begin
      t[2*j]   = key_q[j][31:0];
      t[2*j+1] = key_q[j][63:32];
    end
    for (int i = 0; i < rounds_of(klen_q); i++) begin
      if (klen_q == KLEN_128) begin
        d = Delta[i % 4];
        for (int j = 0; j < 4; j++) t[j] = rol(t[j] + rol(d, i + j), KeyRot[j]);
        rk_q[6*i] = t[0]; rk_q[6*i+1] = t[1]; rk_q[6*i+2] = t[2];
        rk_q[6*i+3] = t[1]; rk_q[6*i+4] = t[3]; rk_q[6*i+5] = t[1];
      end else if (klen_q == KLEN_192) begin
        d = Delta[i % 6];
        for (int j = 0; j < 6; j++) begin
          t[j] = rol(t[j] + rol(d, i + j), KeyRot[j]);
          rk_q[6*i+j] = t[j];
        end
      end else begin
        d = Delta[i % 8];
        for (int j = 0; j < 6; j++) begin
          kk = (6 * i + j) % 8;
          t[kk] = rol(t[kk] + rol(d, i + j), KeyRot[j]);
          rk_q[6*i+j] = t[kk];
        end
      end
    end
    keys_valid = 1'b1;
  endtask

  function automatic logic [127:0] cipher_block(logic decrypt, logic [127:0] blk);
    logic [31:0] x [4];
    logic [31:0] n [4];
    int b;
    for (int w = 0; w < 4; w++) x[w] = blk[32*w +: 32];
    for (int r = 0; r < rounds_of(klen_q); r++) begin
      if (!decrypt) begin
        b = 6 * r;
        n[0] = rol((x[0] ^ rk_q[b]) + (x[1] ^ rk_q[b+1]), 9);
        n[1] = ror((x[1] ^ rk_q[b+2]) + (x[2] ^ rk_q[b+3]), 5);
        n[2] = ror((x[2] ^ rk_q[b+4]) + (x[3] ^ rk_q[b+5]), 3);
        n[3] = x[0];
      end else begin
        b = 6 * (rounds_of(klen_q) - 1 - r);
        n[0] = x[3];
        n[1] = (ror(x[0], 9) - (n[0] ^ rk_q[b])) ^ rk_q[b+1];
        n[2] = (rol(x[1], 5) - (n[1] ^ rk_q[b+2])) ^ rk_q[b+3];
        n[3] = (rol(x[2], 3) - (n[2] ^ rk_q[b+4])) ^ rk_q[b+5];
      end
      x = n;
    end
    return {x[3], x[2], x[1], x[0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] exp_blk;
    if (!rst_ni) begin
      klen_q = KLEN_128;
      for (int j = 0; j < 4; j++) key_q[j] = '0;
      keys_valid = 1'b0;
      expected_blocks.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_LENGTH: begin
            klen_q = klen_e'(cfg_data_i[1:0]);
            keys_valid = 1'b0;
          end
          CFG_KEY_WORD0, CFG_KEY_WORD1, CFG_KEY_WORD2, CFG_KEY_WORD3: begin
            key_q[cfg_idx_i - CFG_KEY_WORD0] = cfg_data_i;
            keys_valid = 1'b0;
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (!keys_valid) build_schedule();
        expected_blocks.push_back(cipher_block(s_axis_tuser, s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_blocks.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result block %h", m_axis_tdata);
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (exp_blk[63:0] !== m_axis_tdata[63:0]
              || exp_blk[127:64] !== m_axis_tdata[127:64]) begin
            fails++;
            if (fails <= 10)
              $display("result mismatch: expected %h_%h got %h_%h", exp_blk[127:64],
                       exp_blk[63:0], m_axis_tdata[127:64], m_axis_tdata[63:0]);
          end
        end
      end
    end
  end

endmodule

// File: test/tb_lea_block_cipher_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LEA block cipher testbench
// Drives blocks through several key settings and idle patterns; the checker
// predicts every result block and reports mismatches.
// ----------------------------------------------------------------------------
module tb_lea_block_cipher_top
  import lea_pkg::*;
();

  // limit on total run time; generous for every block and key schedule
  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned DrainCycles = 400;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;    // block_low[63:0], block_high[127:64]
  logic         s_axis_tuser = 1'b0;  // operation
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;         // result_low[63:0], result_high[127:64]

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;  // sender gap chance, percent
  int unsigned recv_stall_pct = 0; // receiver stall chance, percent
  int unsigned hold_off = 0;       // long receiver hold-off, in cycles

  always #10 clk_i = ~clk_i;

  lea_block_cipher_top dut (.*);

  lea_block_cipher_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // All four key words plus the length selector
  task automatic load_key(logic [1:0] klen, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    write_reg(CFG_KEY_LENGTH, {62'd0, klen});
    write_reg(CFG_KEY_WORD0, k0);
    write_reg(CFG_KEY_WORD1, k1);
    write_reg(CFG_KEY_WORD2, k2);
    write_reg(CFG_KEY_WORD3, k3);
  endtask

  // Offers one transaction, holding valid across back-to-back items
  task automatic send_block(logic op, logic [127:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [127:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Wait for all results, then let the block settle before reconfiguring
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [127:0] blk;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key, field extremes, both operations
    send_block(1'b0, '0);
    send_block(1'b1, '0);
    send_block(1'b0, '1);
    send_block(1'b1, '1);
    drain();
    // known 128-bit vector key 0f1e2d3c4b5a6978 8796a5b4c3d2e1f0
    load_key(KLEN_128, 64'h78695a4b3c2d1e0f, 64'hf0e1d2c3b4a59687, '1, '1);
    send_block(1'b0, 128'h1f1e1d1c1b1a19181716151413121110);
    send_block(1'b1, 128'h1f1e1d1c1b1a19181716151413121110);
    drain();
    load_key(KLEN_192, '1, '1, '1, '0);
    send_block(1'b0, '1);
    send_block(1'b1, 128'h8000000000000000_0000000000000001);
    drain();
    load_key(KLEN_256, '0, '0, '0, '1);
    send_block(1'b0, 128'h5555aaaa5555aaaa_aaaa5555aaaa5555);
    send_block(1'b1, '1);
    drain();
    // reserved length code behaves as 256-bit
    write_reg(CFG_KEY_LENGTH, {62'd0, KLEN_RSV});
    send_block(1'b0, 128'h1);
    send_block(1'b1, 128'h1);
    drain();
    // write to an unused register index is ignored
    cfg_we_i <= 1'b1; cfg_idx_i <= 3'd7; cfg_data_i <= '1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_block(1'b0, rand_block());
    drain();

    // Random phases: each with a fresh key and one of four idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      load_key(2'($urandom_range(3)), {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
      if (ph == 4) hold_off = 3000;  // hold the result in the core and back up the input
      for (int n = 0; n < 120; n++) begin
        blk = rand_block();
        if ($urandom_range(9) == 0) blk[63:0] = '1;
        if ($urandom_range(9) == 0) blk[127:64] = '0;
        send_block(1'($urandom_range(1)), blk);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
